/* hw/rtl/multichannel_mix_integrate_dump_assert.svh */
// Assertion macros for the mix, integrate and dump block.
`ifndef MULTICHANNEL_MIX_INTEGRATE_DUMP_ASSERT_SVH
`define MULTICHANNEL_MIX_INTEGRATE_DUMP_ASSERT_SVH
// Implication checked every clock, off during reset.
`define MMID_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define MMID_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* hw/rtl/mmid_pkg.sv */
// Shared types and constants of the mix, integrate and dump block.
`default_nettype none
package mmid_pkg;
    localparam int ACC_W = 42;
    localparam int MAG_W = 41;
    localparam int SQ_W  = 84;
    localparam int ISQ_STEPS = 42;

    typedef struct packed {
        logic [2:0]       channel;
        logic [ACC_W-1:0] dot_real;
        logic [ACC_W-1:0] dot_imag;
        logic             last_channel;
    } mmid_res_t;
endpackage
`default_nettype wire

/* hw/rtl/mmid_isqrt.sv */
// Bit-serial floor square root of re^2 + im^2, saturated to 41 bits.
`default_nettype none
module mmid_isqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [mmid_pkg::ACC_W-1:0] re,
    input  wire logic [mmid_pkg::ACC_W-1:0] im,
    output logic                            busy,
    output logic                            done,
    output logic [mmid_pkg::MAG_W-1:0]      root
);
    import mmid_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQA  = 3'd1;
    localparam logic [2:0] S_SQB  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [5:0]       cnt_reg;
    logic [ACC_W-1:0] a_reg, b_reg;
    logic [SQ_W-1:0]  pa_reg, pb_reg;
    // restoring root: remainder, root, radicand shift
    logic [SQ_W+1:0]  rem_reg;
    logic [ACC_W:0]   q_reg;
    logic [SQ_W-1:0]  n_reg;
    logic [SQ_W+1:0]  rem_sh, trial;

    // squares split into 21x42 partial products, in states S_SQA and S_SQB
    logic [62:0] ppa, ppb;
    always_comb begin
        ppa = {21'd0, a_reg} * (state_reg == S_SQA ? {42'd0, a_reg[20:0]}
                                                   : {42'd0, 21'(a_reg[41:21])});
        ppb = {21'd0, b_reg} * (state_reg == S_SQA ? {42'd0, b_reg[20:0]}
                                                   : {42'd0, 21'(b_reg[41:21])});
    end

    always_comb begin
        rem_sh = {rem_reg[SQ_W-1:0], n_reg[SQ_W-1:SQ_W-2]};
        trial  = {{(SQ_W-ACC_W-1){1'b0}}, q_reg, 2'b01};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_SQA;
            S_SQA:  state_next = S_SQB;
            S_SQB:  state_next = S_SUM;
            S_SUM:  state_next = S_RUN;
            S_RUN:  if (cnt_reg == 6'(ISQ_STEPS)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end else begin
            state_reg <= state_next;
            done      <= (state_reg == S_RUN) && (cnt_reg == 6'(ISQ_STEPS));
        end
        unique case (state_reg)
            S_IDLE: begin
                a_reg <= re[ACC_W-1] ? -re : re;
                b_reg <= im[ACC_W-1] ? -im : im;
            end
            S_SQA: begin
                pa_reg <= {21'd0, ppa};
                pb_reg <= {21'd0, ppb};
            end
            S_SQB: begin
                pa_reg <= pa_reg + {ppa, 21'd0};
                pb_reg <= pb_reg + {ppb, 21'd0};
            end
            S_SUM: begin
                n_reg   <= pa_reg + pb_reg;
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            S_RUN: begin
                if (cnt_reg != 6'(ISQ_STEPS)) begin
                    n_reg   <= {n_reg[SQ_W-3:0], 2'b00};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (rem_sh >= trial) begin
                        rem_reg <= rem_sh - trial;
                        q_reg   <= {q_reg[ACC_W-1:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[ACC_W-1:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign root = q_reg[ACC_W:MAG_W] != 2'b00 ? {MAG_W{1'b1}} : q_reg[MAG_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/multichannel_mix_integrate_dump.sv */
// Top level: weight memories, accumulator memory, sequencer and result register.
//
//  channel  | direction | handshake          | word
//  s_       | in        | s_valid / s_ready  | mode, sample or weight write
//  m_       | out       | m_valid / m_ready  | one channel result
//  apb      | in        | psel/penable       | channel_count, block_length
//
// A sample runs through these steps (clamped channel count): accept,
// one channel per cycle through the memories, then drain v1_reg and v2_reg.
// At block end each channel is dumped: read, square root, output; inactive
// accumulators are then cleared one per cycle. Reset clears accumulators by a
// sweep over all MAX_CHANNELS entries; weight memories are not cleared.
// Output stalls hold the dump; no input is taken until all results are delivered.
`default_nettype none
module multichannel_mix_integrate_dump #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_BLOCK    = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [15:0] s_sample_i,
    input  wire logic [15:0] s_sample_q,
    input  wire logic [2:0]  s_weight_channel,
    input  wire logic [8:0]  s_weight_position,
    input  wire logic [15:0] s_weight_real,
    input  wire logic [15:0] s_weight_imag,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_channel,
    output logic [41:0]      m_dot_real,
    output logic [41:0]      m_dot_imag,
    output logic [40:0]      m_magnitude,
    output logic             m_last_channel,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mmid_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int POS_W = $clog2(MAX_BLOCK);
    localparam int WA_W  = CH_W + POS_W;
    localparam int NCH_W = $clog2(MAX_CHANNELS + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_DRD  = 3'd3;
    localparam logic [2:0] S_DSQ  = 3'd4;
    localparam logic [2:0] S_DOUT = 3'd5;

    localparam logic [2:0] ADDR_CH  = 3'd0;
    localparam logic [2:0] ADDR_LEN = 3'd4;

    // configuration
    logic [3:0] cnt_cfg_reg;
    logic [9:0] len_cfg_reg;
    wire cfg_wr = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_cfg_reg <= 4'd1;
            len_cfg_reg <= 10'd1;
        end else if (cfg_wr) begin
            if (paddr == ADDR_CH)  cnt_cfg_reg <= pwdata[3:0];
            if (paddr == ADDR_LEN) len_cfg_reg <= pwdata[9:0];
        end
    end
    always_comb begin
        unique case (paddr)
            ADDR_CH:  prdata = {28'd0, cnt_cfg_reg};
            ADDR_LEN: prdata = {22'd0, len_cfg_reg};
            default:  prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // clamped configuration
    logic [NCH_W-1:0] nch;
    logic [12:0]      blen;
    always_comb begin
        if (cnt_cfg_reg == 4'd0) nch = NCH_W'(1);
        else if (32'(cnt_cfg_reg) > MAX_CHANNELS) nch = NCH_W'(MAX_CHANNELS);
        else nch = NCH_W'(cnt_cfg_reg);
        if (len_cfg_reg == 10'd0) blen = 13'd1;
        else if (32'(len_cfg_reg) > MAX_BLOCK) blen = 13'(MAX_BLOCK);
        else blen = 13'(len_cfg_reg);
    end

    logic [2:0]        state_reg;
    logic [CH_W:0]     ch_reg;     // issue counter
    logic [POS_W-1:0]  pos_reg;
    logic signed [15:0] si_reg, sq_reg;
    logic              end_reg;

    // weight memories
    logic [15:0] wr_mem [MAX_CHANNELS*MAX_BLOCK];
    logic [15:0] wi_mem [MAX_CHANNELS*MAX_BLOCK];
    logic signed [15:0] wr_rd, wi_rd;
    logic [WA_W-1:0] w_raddr;
    wire s_acc = s_valid && s_ready;
    wire w_ok = (32'(s_weight_channel) < MAX_CHANNELS) &&
                (32'(s_weight_position) < MAX_BLOCK);
    wire w_we = s_acc && s_mode && w_ok;
    wire [WA_W-1:0] w_waddr = {CH_W'(s_weight_channel), POS_W'(s_weight_position)};
    assign w_raddr = {ch_reg[CH_W-1:0], pos_reg};
    always_ff @(posedge aclk) begin
        if (w_we) begin
            wr_mem[w_waddr] <= s_weight_real;
            wi_mem[w_waddr] <= s_weight_imag;
        end
        wr_rd <= wr_mem[w_raddr];
        wi_rd <= wi_mem[w_raddr];
    end

    // accumulator memory, one port read, one write
    logic [2*ACC_W-1:0] acc_mem [MAX_CHANNELS];
    logic [2*ACC_W-1:0] acc_rd;
    logic               acc_we;
    logic [CH_W-1:0]    acc_waddr;
    logic [2*ACC_W-1:0] acc_wdata;
    always_ff @(posedge aclk) begin
        if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
        acc_rd <= acc_mem[ch_reg[CH_W-1:0]];
    end

    // stage 1: read issued last cycle, multiply now
    logic            v1_reg;
    logic [CH_W-1:0] c1_reg;
    logic signed [31:0] p_ii, p_qq, p_iq, p_qi;
    always_comb begin
        p_ii = si_reg * wr_rd;
        p_qq = sq_reg * wi_rd;
        p_iq = si_reg * wi_rd;
        p_qi = sq_reg * wr_rd;
    end
    logic            v2_reg;
    logic [CH_W-1:0] c2_reg;
    logic signed [32:0] pr_reg, pi_reg;
    always_ff @(posedge aclk) begin
        pr_reg <= 33'(p_ii) - 33'(p_qq);
        pi_reg <= 33'(p_iq) + 33'(p_qi);
        c2_reg <= c1_reg;
    end
    // acc_rd lines up with the products, not with pr_reg/pi_reg; hold it
    logic [2*ACC_W-1:0] acc_d_reg;
    always_ff @(posedge aclk) acc_d_reg <= acc_rd;

    // isqrt
    logic isq_start, isq_busy, isq_done;
    logic [MAG_W-1:0] isq_root;
    mmid_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(isq_start),
        .re(acc_rd[2*ACC_W-1:ACC_W]), .im(acc_rd[ACC_W-1:0]),
        .busy(isq_busy), .done(isq_done), .root(isq_root)
    );

    mmid_res_t res_reg;
    logic last_c;
    assign last_c = (ch_reg == (CH_W+1)'(nch - NCH_W'(1)));

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = c2_reg;
        acc_wdata = {acc_d_reg[2*ACC_W-1:ACC_W] + ACC_W'(signed'(pr_reg)),
                     acc_d_reg[ACC_W-1:0] + ACC_W'(signed'(pi_reg))};
        if (state_reg == S_CLR) begin
            acc_we    = 1'b1;
            acc_waddr = ch_reg[CH_W-1:0];
            acc_wdata = '0;
        end else if (v2_reg) begin
            acc_we = 1'b1;
        end else if (state_reg == S_DOUT && m_valid && m_ready) begin
            acc_we    = 1'b1;
            acc_waddr = ch_reg[CH_W-1:0];
            acc_wdata = '0;
        end
    end

    assign isq_start = (state_reg == S_DSQ) && !isq_busy && !isq_done;
    assign s_ready   = (state_reg == S_IDLE);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            ch_reg    <= '0;
            pos_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
            v1_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    ch_reg <= ch_reg + 1'b1;
                    if (ch_reg == (CH_W+1)'(MAX_CHANNELS - 1)) begin
                        ch_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc && !s_mode) begin
                        si_reg    <= s_sample_i;
                        sq_reg    <= s_sample_q;
                        end_reg   <= (14'(pos_reg) + 14'd1 >= 14'(blen));
                        ch_reg    <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if ((CH_W+1)'(ch_reg) < (CH_W+1)'(nch)) begin
                        v1_reg <= 1'b1;
                        c1_reg <= ch_reg[CH_W-1:0];
                        ch_reg <= ch_reg + 1'b1;
                    end else if (!v1_reg && !v2_reg) begin
                        ch_reg <= '0;
                        if (end_reg) begin
                            pos_reg   <= '0;
                            state_reg <= S_DRD;
                        end else begin
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_DRD: state_reg <= S_DSQ;
                S_DSQ: begin
                    if (isq_start) begin
                        res_reg.channel      <= 3'(ch_reg);
                        res_reg.dot_real     <= acc_rd[2*ACC_W-1:ACC_W];
                        res_reg.dot_imag     <= acc_rd[ACC_W-1:0];
                        res_reg.last_channel <= last_c;
                    end
                    if (isq_done) begin
                        m_magnitude <= isq_root;
                        m_valid     <= 1'b1;
                        state_reg   <= S_DOUT;
                    end
                end
                S_DOUT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        ch_reg  <= ch_reg + 1'b1;
                        if ((CH_W+1)'(ch_reg) + 1'b1 >= (CH_W+1)'(MAX_CHANNELS))
                            state_reg <= S_IDLE;
                        else if (last_c)
                            state_reg <= S_CLR;
                        else
                            state_reg <= S_DRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_channel      = res_reg.channel;
    assign m_dot_real     = res_reg.dot_real;
    assign m_dot_imag     = res_reg.dot_imag;
    assign m_last_channel = res_reg.last_channel && m_valid;

`include "multichannel_mix_integrate_dump_assert.svh"
    `MMID_ASSERT_IMP(a_no_in_in_dump, aclk, aresetn, m_valid, !s_ready)
    `MMID_ASSERT_NXT(a_hold_out, aclk, aresetn, m_valid && !m_ready, m_valid)
    `MMID_ASSERT_IMP(a_mac_idle_out, aclk, aresetn, v2_reg, !m_valid)
endmodule
`default_nettype wire
